// ===== rtl/paes_pkg.sv =====
package paes_pkg;

  localparam int NUM_LEVELS  = 8;
  localparam int LEVEL_DEPTH = 16;
  localparam int ID_BITS     = 8;

  localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int Q_W    = LVL_W + 1;
  localparam int NQ     = 2 ** Q_W;
  localparam int PTR_W  = $clog2(LEVEL_DEPTH);
  localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int ADDR_W = Q_W + PTR_W;
  localparam int MEM_DEPTH = 2 ** ADDR_W;

  localparam int CFG_W  = 4;
  localparam int PRIO_W = 3;
  localparam int PRI_IN_W = 4;

  localparam logic [CFG_W-1:0] LEVELS_RESET = CFG_W'(4);

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TAKE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic             found;
    logic [LVL_W-1:0] level;
  } pick_t;

endpackage

// ===== rtl/paes_in_if.sv =====
interface paes_in_if import paes_pkg::*; ();
  logic                       valid;
  logic                       ready;
  op_t                        operation;
  logic [ID_BITS-1:0]         proc_id;
  logic signed [PRI_IN_W-1:0] dynamic_priority;
  logic [PRI_IN_W-1:0]        static_prio;

  modport source (output valid, operation, proc_id, dynamic_priority, static_prio,
                  input ready);
  modport sink   (input valid, operation, proc_id, dynamic_priority, static_prio,
                  output ready);
endinterface

// ===== rtl/paes_out_if.sv =====
interface paes_out_if import paes_pkg::*; ();
  logic               valid;
  logic               ready;
  status_t            status;
  logic [ID_BITS-1:0] next_id;
  logic [PRIO_W-1:0]  priority_now;
  logic               banks_swapped;

  modport source (output valid, status, next_id, priority_now, banks_swapped,
                  input ready);
  modport sink   (input valid, status, next_id, priority_now, banks_swapped,
                  output ready);
endinterface

// ===== rtl/priority_active_expired_scheduler.sv =====
// Two-bank (active/expired) priority ready-queue scheduler. Each request beat is
// an add or a take-next and yields exactly one response beat. Queue state
// (counts, heads, tails, bank select) is updated in the cycle the request is
// accepted; the queue memory read for a take-next lands in the following cycle,
// and a response passes the read stage and then the response register. A new
// request can be taken every cycle while the response side keeps up. The
// response register and the memory-read stage decouple the two sides, so a
// request is still taken while one finished response waits if the read stage
// is empty. levels_in_use is written via cfg_write/cfg_data and must only
// change while the block is idle; no clearing pass is needed after reset.
module priority_active_expired_scheduler import paes_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [CFG_W-1:0] cfg_data,
  paes_in_if.sink          req,
  paes_out_if.source       rsp
);

  logic [CFG_W-1:0] levels_in_use;
  logic [CFG_W:0]   levels_eff;
  logic             bank;
  logic [CNT_W-1:0] count [NQ];
  logic [PTR_W-1:0] head  [NQ];
  logic [PTR_W-1:0] tail  [NQ];

  // read stage
  logic               s1_valid;
  status_t            s1_status;
  logic [ID_BITS-1:0] s1_id;
  logic [LVL_W-1:0]   s1_lvl;
  logic               s1_swapped;
  logic               s1_from_ram;
  logic               s1_adv;
  logic               acc;

  logic [NUM_LEVELS-1:0] ne0, ne1;
  pick_t                 pick0, pick1, pick_act, pick_oth;

  logic             expired;
  logic [PRI_IN_W-1:0] tgt_raw;
  logic             tgt_ok;
  logic [LVL_W-1:0] tgt_lvl;
  logic [Q_W-1:0]   qa;
  logic             add_full;
  logic             add_do;

  logic             pop_bank;
  logic             pop_found;
  logic [LVL_W-1:0] pop_lvl;
  logic [Q_W-1:0]   qp;
  logic             take_do;

  status_t            st_next;
  logic [LVL_W-1:0]   lvl_next;
  logic [ID_BITS-1:0] ram_rdata;

  always_comb begin
    if (levels_in_use == '0) begin
      levels_eff = (CFG_W + 1)'(1);
    end else if ({1'b0, levels_in_use} > (CFG_W + 1)'(NUM_LEVELS)) begin
      levels_eff = (CFG_W + 1)'(NUM_LEVELS);
    end else begin
      levels_eff = {1'b0, levels_in_use};
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_LEVELS; l++) begin
      ne0[l] = count[{1'b0, LVL_W'(l)}] != '0;
      ne1[l] = count[{1'b1, LVL_W'(l)}] != '0;
    end
  end

  paes_pick u_pick0 (.nonempty(ne0), .levels(levels_eff), .pick(pick0));
  paes_pick u_pick1 (.nonempty(ne1), .levels(levels_eff), .pick(pick1));

  assign pick_act = bank ? pick1 : pick0;
  assign pick_oth = bank ? pick0 : pick1;

  // add path: an expired process refills to static - 1 in the other bank
  assign expired = req.dynamic_priority[PRI_IN_W-1];
  assign tgt_raw = expired ? (req.static_prio - PRI_IN_W'(1))
                           : req.dynamic_priority;
  assign tgt_ok  = !(expired && req.static_prio == '0)
                   && ({1'b0, tgt_raw} < levels_eff);
  assign tgt_lvl = tgt_raw[LVL_W-1:0];
  assign qa      = {bank ^ expired, tgt_lvl};
  assign add_full = count[qa] == CNT_W'(LEVEL_DEPTH);

  // take path: fall back to the other bank (a swap) when the active one is empty
  assign pop_bank  = pick_act.found ? bank : ~bank;
  assign pop_found = pick_act.found || pick_oth.found;
  assign pop_lvl   = pick_act.found ? pick_act.level : pick_oth.level;
  assign qp        = {pop_bank, pop_lvl};

  assign s1_adv    = !rsp.valid || rsp.ready;
  assign req.ready = !s1_valid || s1_adv;
  assign acc       = req.valid && req.ready;
  assign add_do    = acc && req.operation == OP_ADD && tgt_ok && !add_full;
  assign take_do   = acc && req.operation == OP_TAKE && pop_found;

  always_comb begin
    st_next  = ST_OK;
    lvl_next = '0;
    if (req.operation == OP_ADD) begin
      if (!tgt_ok) begin
        st_next = ST_RANGE;
      end else begin
        lvl_next = tgt_lvl;
        if (add_full) begin
          st_next = ST_FULL;
        end
      end
    end else if (pop_found) begin
      lvl_next = pop_lvl;
    end else begin
      st_next = ST_EMPTY;
    end
  end

  paes_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (add_do),
    .waddr ({qa, tail[qa]}),
    .wdata (req.proc_id),
    .re    (take_do),
    .raddr ({qp, head[qp]}),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      levels_in_use <= LEVELS_RESET;
    end else if (cfg_write) begin
      levels_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank <= 1'b0;
      for (int i = 0; i < NQ; i++) begin
        count[i] <= '0;
        head[i]  <= '0;
        tail[i]  <= '0;
      end
    end else begin
      if (acc && req.operation == OP_TAKE && !pick_act.found) begin
        bank <= ~bank;
      end
      if (add_do) begin
        count[qa] <= count[qa] + CNT_W'(1);
        tail[qa]  <= (tail[qa] == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : tail[qa] + PTR_W'(1);
      end
      if (take_do) begin
        count[qp] <= count[qp] - CNT_W'(1);
        head[qp]  <= (head[qp] == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : head[qp] + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_status   <= st_next;
      s1_lvl      <= lvl_next;
      s1_id       <= (req.operation == OP_ADD) ? req.proc_id : '0;
      s1_swapped  <= (req.operation == OP_TAKE) && !pick_act.found;
      s1_from_ram <= take_do;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (s1_adv) begin
      rsp.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      rsp.status        <= s1_status;
      rsp.next_id       <= s1_from_ram ? ram_rdata : s1_id;
      rsp.priority_now  <= PRIO_W'({{PRIO_W{1'b0}}, s1_lvl});
      rsp.banks_swapped <= s1_swapped;
    end
  end

endmodule

// ===== rtl/paes_ram.sv =====
module paes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/paes_pick.sv =====
module paes_pick import paes_pkg::*; (
  input  logic [NUM_LEVELS-1:0] nonempty,
  input  logic [CFG_W:0]        levels,
  output pick_t                 pick
);

  // highest level wins: later iterations overwrite earlier ones
  always_comb begin
    pick = '0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (nonempty[l] && ((CFG_W + 1)'(l) < levels)) begin
        pick.found = 1'b1;
        pick.level = LVL_W'(l);
      end
    end
  end

endmodule

// ===== sim/tb_priority_active_expired_scheduler.sv =====
`timescale 1ns / 1ps

module tb_priority_active_expired_scheduler;
  import paes_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTS     = 100;

  typedef struct packed {
    op_t                        op;
    logic [ID_BITS-1:0]         id;
    logic signed [PRI_IN_W-1:0] dyn;
    logic [PRI_IN_W-1:0]        stat;
  } sched_cmd_t;

  typedef struct packed {
    status_t            status;
    logic [ID_BITS-1:0] id;
    logic [PRIO_W-1:0]  prio;
    logic               swapped;
  } sched_pick_t;

  logic             clk;
  logic             rst;
  logic             cfg_write;
  logic [CFG_W-1:0] cfg_data;

  paes_in_if  req_if ();
  paes_out_if rsp_if ();

  priority_active_expired_scheduler u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  always #10 clk = ~clk;

  // shadow of the scheduler state
  logic [ID_BITS-1:0] slot_mem [2*NUM_LEVELS][LEVEL_DEPTH];
  int                 slot_head [2*NUM_LEVELS];
  int                 slot_cnt  [2*NUM_LEVELS];
  int                 cur_bank;
  logic [CFG_W-1:0]   levels_reg;

  sched_cmd_t  pending_cmds [$];
  sched_pick_t expected_picks [$];
  sched_cmd_t  cur_cmd;

  int mismatches;
  int gap_left;
  int stall_left;
  int quiet_cycles;
  bit idle_on;

  function automatic int eff_levels();
    if (levels_reg == 0) return 1;
    if (levels_reg > NUM_LEVELS) return NUM_LEVELS;
    return int'(levels_reg);
  endfunction

  function automatic bit pop_highest(output logic [ID_BITS-1:0] id, output int lvl);
    int q;
    for (int l = eff_levels() - 1; l >= 0; l--) begin
      q = cur_bank * NUM_LEVELS + l;
      if (slot_cnt[q] != 0) begin
        id           = slot_mem[q][slot_head[q]];
        slot_head[q] = (slot_head[q] + 1) % LEVEL_DEPTH;
        slot_cnt[q]  = slot_cnt[q] - 1;
        lvl          = l;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic sched_pick_t predict_schedule(sched_cmd_t c);
    sched_pick_t        e;
    int                 tgt;
    int                 bank;
    int                 q;
    int                 lvl;
    logic [ID_BITS-1:0] id;
    e.status  = ST_OK;
    e.id      = '0;
    e.prio    = '0;
    e.swapped = 1'b0;
    if (c.op == OP_ADD) begin
      e.id = c.id;
      bank = cur_bank;
      tgt  = int'($signed(c.dyn));
      if ($signed(c.dyn) < 0) begin
        // expired: refill from static priority into the other bank
        tgt  = int'(c.stat) - 1;
        bank = cur_bank ^ 1;
      end
      if (tgt < 0 || tgt >= eff_levels()) begin
        e.status = ST_RANGE;
      end else begin
        q      = bank * NUM_LEVELS + tgt;
        e.prio = tgt[PRIO_W-1:0];
        if (slot_cnt[q] >= LEVEL_DEPTH) begin
          e.status = ST_FULL;
        end else begin
          slot_mem[q][(slot_head[q] + slot_cnt[q]) % LEVEL_DEPTH] = c.id;
          slot_cnt[q] = slot_cnt[q] + 1;
        end
      end
    end else begin
      id  = '0;
      lvl = 0;
      if (!pop_highest(id, lvl)) begin
        cur_bank  = cur_bank ^ 1;
        e.swapped = 1'b1;
        if (!pop_highest(id, lvl)) begin
          e.status = ST_EMPTY;
          id       = '0;
          lvl      = 0;
        end
      end
      e.id   = id;
      e.prio = lvl[PRIO_W-1:0];
    end
    return e;
  endfunction

  function automatic sched_cmd_t mk_cmd(op_t op, int id, int dyn, int stat);
    sched_cmd_t c;
    c.op   = op;
    c.id   = id[ID_BITS-1:0];
    c.dyn  = dyn[PRI_IN_W-1:0];
    c.stat = stat[PRI_IN_W-1:0];
    return c;
  endfunction

  // mostly well-formed adds and takes; a tenth of adds carry raw priority bits
  function automatic sched_cmd_t random_cmd(int take_pct);
    sched_cmd_t c;
    int         lv;
    lv     = eff_levels();
    c.op   = OP_ADD;
    c.id   = ID_BITS'($urandom);
    c.dyn  = PRI_IN_W'($urandom);
    c.stat = PRI_IN_W'($urandom);
    if ($urandom_range(99) < take_pct) begin
      c.op = OP_TAKE;
    end else if ($urandom_range(9) != 0) begin
      if ($urandom_range(3) == 0) begin
        c.dyn  = PRI_IN_W'(-1);
        c.stat = PRI_IN_W'($urandom_range(lv, 1));
      end else begin
        c.dyn = PRI_IN_W'($urandom_range(lv - 1, 0));
      end
    end
    return c;
  endfunction

  task automatic queue_cmd(sched_cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_PRINTS) $display("%0t: MISMATCH %s", $time, msg);
    mismatches++;
  endtask

  // sampled on the falling edge, once the rising-edge updates have settled
  task automatic wait_drained();
    @(negedge clk);
    while (pending_cmds.size() != 0 || req_if.valid || expected_picks.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(int levels, int take_pct, int n);
    wait_drained();
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= levels[CFG_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    levels_reg = levels[CFG_W-1:0];
    repeat (n) queue_cmd(random_cmd(take_pct));
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
      gap_left = 0;
    end else if (!req_if.valid || req_if.ready) begin
      if (req_if.valid)
        expected_picks.insert(expected_picks.size(), predict_schedule(cur_cmd));
      if (gap_left > 0) begin
        gap_left--;
        req_if.valid <= 1'b0;
      end else if (pending_cmds.size() == 0) begin
        req_if.valid <= 1'b0;
      end else if (idle_on && $urandom_range(7) == 0) begin
        gap_left = $urandom_range(4, 0);
        req_if.valid <= 1'b0;
      end else begin
        cur_cmd = pending_cmds[0];
        pending_cmds.delete(0);
        req_if.valid            <= 1'b1;
        req_if.operation        <= cur_cmd.op;
        req_if.proc_id          <= cur_cmd.id;
        req_if.dynamic_priority <= cur_cmd.dyn;
        req_if.static_prio      <= cur_cmd.stat;
      end
    end
  end

  // response monitor and sink stalls
  always @(posedge clk) begin
    sched_pick_t exp_pick;
    if (rst) begin
      rsp_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_picks.size() == 0) begin
          report_mismatch($sformatf("beat with nothing expected: id %0h", rsp_if.next_id));
        end else begin
          exp_pick = expected_picks[0];
          expected_picks.delete(0);
          if (rsp_if.status !== exp_pick.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      rsp_if.status, exp_pick.status));
          if (rsp_if.next_id !== exp_pick.id)
            report_mismatch($sformatf("next_id got %0h want %0h",
                                      rsp_if.next_id, exp_pick.id));
          if (rsp_if.priority_now !== exp_pick.prio)
            report_mismatch($sformatf("priority_now got %0d want %0d",
                                      rsp_if.priority_now, exp_pick.prio));
          if (rsp_if.banks_swapped !== exp_pick.swapped)
            report_mismatch($sformatf("banks_swapped got %0b want %0b",
                                      rsp_if.banks_swapped, exp_pick.swapped));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(7) == 0) begin
        stall_left = $urandom_range(4, 0);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** priority_active_expired_scheduler: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk                     = 1'b0;
    rst                     = 1'b1;
    cfg_write               = 1'b0;
    cfg_data                = '0;
    req_if.valid            = 1'b0;
    req_if.operation        = OP_ADD;
    req_if.proc_id          = '0;
    req_if.dynamic_priority = '0;
    req_if.static_prio      = '0;
    rsp_if.ready            = 1'b0;
    quiet_cycles            = 0;
    mismatches              = 0;
    idle_on                 = 1'b1;
    cur_bank                = 0;
    levels_reg              = LEVELS_RESET;
    for (int q = 0; q < 2*NUM_LEVELS; q++) begin
      slot_head[q] = 0;
      slot_cnt[q]  = 0;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed, at the reset level count of four
    queue_cmd(mk_cmd(OP_TAKE, 8'h00,  0,  0));  // nothing ready, banks swap
    queue_cmd(mk_cmd(OP_ADD,  8'hFF,  3,  1));
    queue_cmd(mk_cmd(OP_ADD,  8'h00,  0,  8));
    queue_cmd(mk_cmd(OP_ADD,  8'h5A,  4,  2));  // just past the top level
    queue_cmd(mk_cmd(OP_ADD,  8'hA5,  7, 15));
    queue_cmd(mk_cmd(OP_ADD,  8'h11, -1,  4));  // expired, top level
    queue_cmd(mk_cmd(OP_ADD,  8'h22, -1,  0));  // refill lands below zero
    queue_cmd(mk_cmd(OP_ADD,  8'h33, -8, 15));
    queue_cmd(mk_cmd(OP_ADD,  8'h44, -1,  1));
    queue_cmd(mk_cmd(OP_ADD,  8'h55, -2,  5));
    queue_cmd(mk_cmd(OP_TAKE, 8'hC3,  5,  9));
    queue_cmd(mk_cmd(OP_TAKE, 8'h3C, -3,  6));
    queue_cmd(mk_cmd(OP_TAKE, 8'hFF,  7, 15));  // active empty: swap to expired
    queue_cmd(mk_cmd(OP_TAKE, 8'h00, -8,  0));
    queue_cmd(mk_cmd(OP_TAKE, 8'h81,  1,  3));
    queue_cmd(mk_cmd(OP_TAKE, 8'h7E,  2, 12));

    // level counts include 0 and 15, which clamp to 1 and the maximum;
    // queues carry over between phases so shrinking hides stored entries
    run_phase(8, 40, 120);
    run_phase(3, 30, 120);
    run_phase(1, 15, 120);
    run_phase(0, 60, 120);
    run_phase(15, 35, 120);
    run_phase(2, 50, 120);
    run_phase(5, 25, 120);
    run_phase(6, 55, 120);
    run_phase(7, 45, 120);
    wait_drained();
    idle_on = 1'b0;
    run_phase(8, 50, 120);

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("** priority_active_expired_scheduler: PASSED **");
    end else begin
      $display("** priority_active_expired_scheduler: FAILED **");
    end
    $finish;
  end

endmodule
